FILE: rtl/b64enc_pkg.sv
// b64enc_pkg: shared types, constants and the character mapping for the base64 encoder
// used by the front, queue and back modules; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package b64enc_pkg;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	localparam logic [1:0] PHASE_0 = 2'd0;
	localparam logic [1:0] PHASE_1 = 2'd1;
	localparam logic [1:0] PHASE_2 = 2'd2;

	// one accepted byte turned into its one to four output characters
	typedef struct packed {
		logic [2:0]      count;
		logic            fin;
		logic [3:0][7:0] chars;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] v8;
		v8 = {2'b00, v};
		if (v < 6'd26)
			sextet_char = v8 + 8'd65;
		else if (v < 6'd52)
			sextet_char = v8 + 8'd71;
		else if (v < 6'd62)
			sextet_char = v8 - 8'd4;
		else if (v == 6'd62)
			sextet_char = 8'h2B;
		else
			sextet_char = 8'h2F;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/b64enc_front.sv
// b64enc_front: accepts message bytes, tracks group phase and leftover bits,
// and builds the character job for each byte; depends on b64enc_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64enc_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic [7:0]           data_byte,
	input  wire logic                 final_byte,
	input  wire logic                 queue_full,
	output logic                      in_stall,
	output logic                      push,
	output b64enc_pkg::job_t          job
);

	logic [1:0] phase_q;
	logic [3:0] left_q;
	logic [1:0] phase_eff;
	logic [1:0] phase_nxt;
	logic [3:0] left_nxt;

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	// an out-of-range phase restarts the group
	assign phase_eff = (phase_q == 2'd3) ? b64enc_pkg::PHASE_0 : phase_q;

	always_comb begin
		job.fin   = final_byte;
		job.chars = '0;
		job.count = 3'd1;
		phase_nxt = b64enc_pkg::PHASE_0;
		left_nxt  = 4'd0;
		unique case (phase_eff)
			b64enc_pkg::PHASE_0: begin
				job.chars[0] = b64enc_pkg::sextet_char(data_byte[7:2]);
				job.chars[1] = b64enc_pkg::sextet_char({data_byte[1:0], 4'd0});
				job.chars[2] = b64enc_pkg::PAD_CHAR;
				job.chars[3] = b64enc_pkg::PAD_CHAR;
				job.count    = final_byte ? 3'd4 : 3'd1;
				phase_nxt    = b64enc_pkg::PHASE_1;
				left_nxt     = {2'b00, data_byte[1:0]};
			end
			b64enc_pkg::PHASE_1: begin
				job.chars[0] = b64enc_pkg::sextet_char({left_q[1:0], data_byte[7:4]});
				job.chars[1] = b64enc_pkg::sextet_char({data_byte[3:0], 2'd0});
				job.chars[2] = b64enc_pkg::PAD_CHAR;
				job.count    = final_byte ? 3'd3 : 3'd1;
				phase_nxt    = b64enc_pkg::PHASE_2;
				left_nxt     = data_byte[3:0];
			end
			default: begin
				job.chars[0] = b64enc_pkg::sextet_char({left_q, data_byte[7:6]});
				job.chars[1] = b64enc_pkg::sextet_char(data_byte[5:0]);
				job.count    = 3'd2;
			end
		endcase
		if (final_byte) begin
			phase_nxt = b64enc_pkg::PHASE_0;
			left_nxt  = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= b64enc_pkg::PHASE_0;
			left_q  <= 4'd0;
		end else if (push) begin
			phase_q <= phase_nxt;
			left_q  <= left_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/b64enc_queue.sv
// b64enc_queue: short fifo of character jobs between the front and back parts
// depends on b64enc_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64enc_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	input  wire b64enc_pkg::job_t          push_job,
	input  wire logic                      pop,
	output b64enc_pkg::job_t               head_job,
	output b64enc_pkg::queue_status_t      status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	b64enc_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign status.full  = (count_q == FULL_CNT);
	assign status.empty = (count_q == '0);
	assign head_job     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count above depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		status.full && !pop |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		status.empty |-> !pop)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: rtl/b64enc_back.sv
// b64enc_back: takes character jobs from the queue and sends one character per
// transaction through a registered output; depends on b64enc_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64enc_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 job_valid,
	input  wire b64enc_pkg::job_t     job_in,
	output logic                      job_pop,
	input  wire logic                 out_stall,
	output logic                      out_valid,
	output logic [7:0]                out_char,
	output logic                      message_end
);

	b64enc_pkg::job_t job_q;
	logic [1:0]       idx_q;
	logic             busy_q;
	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             message_end_q;
	logic             emit;
	logic             at_last;
	logic             take;

	assign emit    = busy_q && (!out_valid_q || !out_stall);
	assign at_last = ({1'b0, idx_q} == (job_q.count - 3'd1));
	// next job loads in the same cycle the current one sends its last character
	assign take    = job_valid && (!busy_q || (emit && at_last));
	assign job_pop = take;

	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign message_end = message_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (take) begin
				busy_q <= 1'b1;
				idx_q  <= 2'd0;
			end else if (emit && at_last) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			job_q <= job_in;
		if (emit) begin
			out_char_q    <= job_q.chars[idx_q];
			message_end_q <= job_q.fin && at_last;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/base64_stream_encoder_unit.sv
// path: each accepted byte passes the job queue, the back job register, then the output register
// throughput: one byte per cycle into the queue unless it is full; the back part sends
// one character per cycle unless out_stall holds it; bytes yield 1 to 4 characters (~1.33 avg)
// the input stalls only while the job queue is full
// reset: arst_n clears group phase, leftover bits, queue pointers and output valid
// base64_stream_encoder_unit: top level joining front, queue and back; uses b64enc_pkg
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       final_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_char,
	output logic            message_end
);

	b64enc_pkg::job_t          front_job;
	b64enc_pkg::job_t          head_job;
	b64enc_pkg::queue_status_t q_status;
	logic                      push;
	logic                      pop;

	b64enc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.queue_full (q_status.full),
		.in_stall   (in_stall),
		.push       (push),
		.job        (front_job)
	);

	b64enc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (front_job),
		.pop      (pop),
		.head_job (head_job),
		.status   (q_status)
	);

	b64enc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (!q_status.empty),
		.job_in      (head_job),
		.job_pop     (pop),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_char    (out_char),
		.message_end (message_end)
	);

endmodule

`default_nettype wire

FILE: dv/tb_base64_stream_encoder_unit.sv
// tb_base64_stream_encoder_unit: self-checking bench for the streaming base64 encoder
// predicts padded characters per accepted byte and checks every output transaction
// depends on rtl/b64enc_pkg.sv and rtl/base64_stream_encoder_unit.sv
`timescale 1ns / 1ps

typedef struct {
	logic [7:0] ch;
	logic       last;
} b64_char_t;

typedef logic [7:0] byte_q_t[$];

class b64_scoreboard;
	logic [1:0]  phase;
	logic [3:0]  carry;
	b64_char_t   pending[$];
	int          faults;
	int          bytes_taken;

	function new();
		phase = b64enc_pkg::PHASE_0;
		carry = 4'd0;
		faults = 0;
		bytes_taken = 0;
	endfunction

	function logic [7:0] char_of(input logic [5:0] v);
		string alpha = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ", "abcdefghijklmnopqrstuvwxyz",
			"0123456789+/"};
		return alpha[v];
	endfunction

	// expected characters for one accepted byte
	function void note_byte(input logic [7:0] b, input logic fin);
		logic [7:0] seq[$];
		b64_char_t  e;
		bytes_taken++;
		if (phase == b64enc_pkg::PHASE_1) begin
			seq = {seq, char_of({carry[1:0], b[7:4]})};
			carry = b[3:0];
			phase = b64enc_pkg::PHASE_2;
		end else if (phase == b64enc_pkg::PHASE_2) begin
			seq = {seq, char_of({carry, b[7:6]})};
			seq = {seq, char_of(b[5:0])};
			carry = 4'd0;
			phase = b64enc_pkg::PHASE_0;
		end else begin
			// an out-of-range phase also counts as a group start
			seq = {seq, char_of(b[7:2])};
			carry = {2'b00, b[1:0]};
			phase = b64enc_pkg::PHASE_1;
		end
		if (fin) begin
			if (phase == b64enc_pkg::PHASE_1) begin
				seq = {seq, char_of({carry[1:0], 4'b0000})};
				seq = {seq, b64enc_pkg::PAD_CHAR};
				seq = {seq, b64enc_pkg::PAD_CHAR};
			end else if (phase == b64enc_pkg::PHASE_2) begin
				seq = {seq, char_of({carry, 2'b00})};
				seq = {seq, b64enc_pkg::PAD_CHAR};
			end
			carry = 4'd0;
			phase = b64enc_pkg::PHASE_0;
		end
		foreach (seq[i]) begin
			e.ch = seq[i];
			e.last = fin && (i == seq.size() - 1);
			pending = {pending, e};
		end
	endfunction

	function void check_char(input logic [7:0] ch, input logic last);
		b64_char_t e;
		if (pending.size() == 0) begin
			faults++;
			if (faults <= 10)
				$display("unexpected char 0x%02h end=%0b", ch, last);
		end else begin
			e = pending.pop_front();
			if (ch !== e.ch || last !== e.last) begin
				faults++;
				if (faults <= 10)
					$display("char mismatch: expected 0x%02h end=%0b, got 0x%02h end=%0b",
						e.ch, e.last, ch, last);
			end
		end
	endfunction
endclass

module tb_base64_stream_encoder_unit;

	localparam int NUM_BYTES   = 450;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'h00;
	logic       final_byte = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_char;
	logic       message_end;

	b64_scoreboard sb = new();
	int            burst_left = 0;
	int            cycle_count = 0;

	base64_stream_encoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.final_byte(final_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.message_end(message_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("base64_stream_encoder_unit verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_char(out_char, message_end);
	end

	// call at a rising edge; returns at the edge where the transaction is taken
	task automatic send_byte(input logic [7:0] b, input logic fin);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
				$urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		final_byte <= fin;
		do @(posedge clk); while (in_stall);
		sb.note_byte(b, fin);
		burst_left--;
	endtask

	task automatic send_message(input byte_q_t msg);
		foreach (msg[i])
			send_byte(msg[i], i == msg.size() - 1);
	endtask

	// receiver: stall pattern changes every so often, one long hold-off mid-run
	initial begin : receiver
		int  mode;
		int  span;
		bit  held;
		logic toggle;
		held = 0;
		toggle = 1'b0;
		@(posedge clk);
		forever begin
			if (!held && sb.bytes_taken >= 150) begin
				held = 1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(10, 60);
				repeat (span) begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 3) == 0);
						2: out_stall <= ($urandom_range(0, 9) < 7);
						default: begin
							toggle = ~toggle;
							out_stall <= toggle;
						end
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin : stimulus
		byte_q_t msg;
		int      len;
		int      target;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short messages ending at each group phase, plus all-zero and all-one bytes
		send_message('{8'h00});
		send_message('{8'hFF});
		send_message('{8'h00, 8'hFF});
		send_message('{8'hFF, 8'h00});
		// final byte completes the group: no pad, '+' and '/' both show up
		send_message('{8'hFB, 8'hFF, 8'hBF});
		send_message('{8'h00, 8'h00, 8'h00, 8'h00});
		send_message('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
		send_message('{8'h4D, 8'h61, 8'h6E});

		target = sb.bytes_taken + NUM_BYTES;
		while (sb.bytes_taken < target) begin
			if ($urandom_range(0, 6) != 0) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) :
					$urandom_range(1, 9);
				msg.delete();
				repeat (len) msg = {msg, 8'($urandom_range(0, 255))};
				send_message(msg);
			end else begin
				// loose bytes with the end flag set at random
				repeat ($urandom_range(1, 6))
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			end
		end
		in_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.faults == 0 && sb.pending.size() == 0)
			$display("base64_stream_encoder_unit verification clean");
		else
			$display("base64_stream_encoder_unit verification failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/b64enc_pkg.sv
rtl/b64enc_front.sv
rtl/b64enc_queue.sv
rtl/b64enc_back.sv
rtl/base64_stream_encoder_unit.sv
dv/tb_base64_stream_encoder_unit.sv
